### sv/scsf_pkg.sv
// Shared types and constants for the capability strip filter.
// Depends on nothing; scsf_core, scsf_outbuf and the top level import it.
package scsf_pkg;

    localparam int unsigned HdrWords = 5;
    localparam int unsigned HdrWidth = 3;

    localparam logic [15:0] CAP_OPCODE = 16'd17;
    localparam logic [15:0] CAP_COUNT  = 16'd2;
    localparam logic [31:0] CAP_ID     = 32'd4450;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Report status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_REMOVED = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;

    localparam int unsigned MaxResults = 3;

    typedef struct packed {
        logic        kind;
        logic [31:0] data_word;
        logic [2:0]  status;
        logic        run_end;
    } result_t;

    // Results produced by one input word, handed to the output buffer
    typedef struct packed {
        logic                        load;
        logic [1:0]                  count;
        result_t [MaxResults-1:0]    items;
    } bundle_t;

endpackage

### sv/scsf_word_if.sv
// Input channel interface: one module word and its final flag.
// Depends on nothing.
interface scsf_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        final_word;

    modport source (output valid, output word, output final_word, input ready);
    modport sink   (input valid, input word, input final_word, output ready);
endinterface

### sv/scsf_result_if.sv
// Output channel interface: kept data words and end-of-stream reports.
// Depends on nothing.
interface scsf_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] data_word;
    logic [2:0]  status;
    logic        run_end;

    modport source (output valid, output kind, output data_word, output status,
                    output run_end, input ready);
    modport sink   (input valid, input kind, input data_word, input status,
                    input run_end, output ready);
endinterface

### sv/scsf_core.sv
// Input register, parser state and per-word result generation.
// Depends on scsf_pkg and scsf_word_if.
module scsf_core
(
    input  logic              clk,
    input  logic              rst_n,
    scsf_word_if.sink         words,
    input  logic              can_load,
    output scsf_pkg::bundle_t bundle
);
    import scsf_pkg::*;

    logic                 in_valid_reg;
    logic [31:0]          in_word_reg;
    logic                 in_final_reg;

    logic [HdrWidth-1:0]  header_left_reg, header_left_next;
    logic [15:0]          words_left_reg, words_left_next;
    logic [31:0]          held_word_reg, held_word_next;
    logic                 holding_reg, holding_next;
    logic                 removed_any_reg, removed_any_next;
    logic                 error_reg, error_next;

    logic                 advance;
    logic [15:0]          op;
    logic [15:0]          cnt;
    logic [2:0]           status;
    logic [1:0]           n;
    result_t [MaxResults-1:0] items;

    assign advance     = in_valid_reg && can_load;
    assign words.ready = !in_valid_reg || advance;
    assign op          = in_word_reg[15:0];
    assign cnt         = in_word_reg[31:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (words.ready)
        begin
            in_valid_reg <= words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (words.ready && words.valid)
        begin
            in_word_reg  <= words.word;
            in_final_reg <= words.final_word;
        end
    end

    always_comb
    begin
        header_left_next = header_left_reg;
        words_left_next  = words_left_reg;
        held_word_next   = held_word_reg;
        holding_next     = holding_reg;
        removed_any_next = removed_any_reg;
        error_next       = error_reg;
        status           = ST_NONE;
        n                = 2'd0;
        items            = '0;

        priority if (error_reg)
        begin
            status = ST_ZERO;
        end
        else if (header_left_reg != '0)
        begin
            items[n] = '{KIND_DATA, in_word_reg, ST_NONE, 1'b0};
            n = n + 2'd1;
            header_left_next = header_left_reg - HdrWidth'(1);
            status = (header_left_next != '0) ? ST_SHORT : ST_NONE;
        end
        else if (words_left_reg == '0)
        begin
            priority if (cnt == '0)
            begin
                error_next = 1'b1;
                status = ST_ZERO;
            end
            else if (op == CAP_OPCODE && cnt == CAP_COUNT)
            begin
                // Hold the candidate until its operand shows up
                held_word_next  = in_word_reg;
                holding_next    = 1'b1;
                words_left_next = 16'd1;
                if (in_final_reg)
                begin
                    items[n] = '{KIND_DATA, in_word_reg, ST_NONE, 1'b0};
                    n = n + 2'd1;
                    holding_next = 1'b0;
                end
                status = ST_TRUNC;
            end
            else
            begin
                items[n] = '{KIND_DATA, in_word_reg, ST_NONE, 1'b0};
                n = n + 2'd1;
                words_left_next = cnt - 16'd1;
            end
        end
        else
        begin
            if (holding_reg)
            begin
                holding_next = 1'b0;
                if (in_word_reg == CAP_ID)
                begin
                    removed_any_next = 1'b1;
                end
                else
                begin
                    items[n] = '{KIND_DATA, held_word_reg, ST_NONE, 1'b0};
                    n = n + 2'd1;
                    items[n] = '{KIND_DATA, in_word_reg, ST_NONE, 1'b0};
                    n = n + 2'd1;
                end
            end
            else
            begin
                items[n] = '{KIND_DATA, in_word_reg, ST_NONE, 1'b0};
                n = n + 2'd1;
            end
            words_left_next = words_left_reg - 16'd1;
        end

        if (in_final_reg)
        begin
            if (status != ST_ZERO && status != ST_SHORT)
            begin
                if (words_left_next != '0)
                begin
                    status = ST_TRUNC;
                end
                else
                begin
                    status = removed_any_next ? ST_REMOVED : ST_NONE;
                end
            end
            items[n] = '{KIND_REPORT, 32'd0, status, 1'b0};
            n = n + 2'd1;
            // Return to the start-of-module state
            header_left_next = HdrWidth'(HdrWords);
            words_left_next  = '0;
            holding_next     = 1'b0;
            removed_any_next = 1'b0;
            error_next       = 1'b0;
        end

        if (n != 2'd0)
        begin
            items[n - 2'd1].run_end = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg <= HdrWidth'(HdrWords);
            words_left_reg  <= '0;
            holding_reg     <= 1'b0;
            removed_any_reg <= 1'b0;
            error_reg       <= 1'b0;
        end
        else if (advance)
        begin
            header_left_reg <= header_left_next;
            words_left_reg  <= words_left_next;
            holding_reg     <= holding_next;
            removed_any_reg <= removed_any_next;
            error_reg       <= error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held_word_reg <= held_word_next;
        end
    end

    assign bundle.load  = advance;
    assign bundle.count = n;
    assign bundle.items = items;

endmodule

### sv/scsf_outbuf.sv
// Three-entry result buffer that drains one result per cycle while the output is ready.
// Depends on scsf_pkg and scsf_result_if.
module scsf_outbuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  scsf_pkg::bundle_t bundle,
    output logic              can_load,
    scsf_result_if.source     results
);
    import scsf_pkg::*;

    result_t [MaxResults-1:0] entry_reg;
    logic [1:0]               count_reg;
    logic                     pop;

    assign pop      = (count_reg != 2'd0) && results.ready;
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (bundle.load)
        begin
            count_reg <= bundle.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle.load)
        begin
            entry_reg <= bundle.items;
        end
        else if (pop)
        begin
            // Advance the queue towards the head
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

    assign results.valid     = (count_reg != 2'd0);
    assign results.kind      = entry_reg[0].kind;
    assign results.data_word = entry_reg[0].data_word;
    assign results.status    = entry_reg[0].status;
    assign results.run_end   = entry_reg[0].run_end;

endmodule

### sv/spirv_capability_strip_filter.sv
// Top level of the capability strip filter: input word register, parser and result buffer.
// Depends on scsf_pkg, scsf_word_if, scsf_result_if, scsf_core and scsf_outbuf.
//
//  channel        dir  payload                                 handshake
//  module_words   in   word[31:0], final_word                  valid/ready
//  results        out  kind, data_word[31:0], status[2:0],     valid/ready
//                      run_end
//
// Each accepted word is registered, parsed combinationally against the
// parser state and its results (zero to three) land in a three-entry
// buffer; while the output is ready, one result leaves per cycle and a word
// that yields at most one result sustains one word per cycle; a released held
// word or a final word adds one or two output beats, during which input stalls.
// Reset restores the start-of-module state: five header words pending,
// no instruction open, nothing held, no error.
module spirv_capability_strip_filter
(
    input  logic          clk,
    input  logic          rst_n,
    scsf_word_if.sink     module_words,
    scsf_result_if.source results
);
    import scsf_pkg::*;

    bundle_t bundle;
    logic    can_load;

    // Parse words and build the result group for each one
    scsf_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .words    (module_words),
        .can_load (can_load),
        .bundle   (bundle)
    );

    // Hold the group and hand it out one word at a time
    scsf_outbuf u_outbuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .bundle   (bundle),
        .can_load (can_load),
        .results  (results)
    );

endmodule
